// ===== design/tcw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tcw_pkg
// Shared types and constants for the text console character writer.
// ============================================================================
package tcw_pkg;

   // Character codes with a special meaning.
   localparam logic [7:0] CODE_BACKSPACE = 8'h08;
   localparam logic [7:0] CODE_LF        = 8'h0A;
   localparam logic [7:0] CODE_CR        = 8'h0D;
   localparam logic [7:0] BLANK_CHAR     = 8'h20;

   // Reset contents of a screen cell and reset attribute.
   localparam logic [15:0] RESET_CELL      = 16'h0F20;
   localparam logic [7:0]  RESET_ATTRIBUTE = 8'h07;

   // Input item kinds.
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COPY,
      ST_BLANK,
      ST_RESP
   } tcw_state_type;

   // Decision of the cursor unit for the character on the request port.
   typedef struct packed {
      logic store;   // a cell is written
      logic scroll;  // the screen scrolls up one line
   } tcw_cursor_type;

endpackage
`default_nettype wire

// ===== design/tcw_screen_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tcw_screen_ram
// Screen cell memory: one write port and one read port with registered data.
// ============================================================================
module tcw_screen_ram #(
   parameter int Depth = 2000,
   parameter int AddrW = 11
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AddrW-1:0] waddr,
   input  wire logic [15:0]      wdata,
   input  wire logic             re,
   input  wire logic [AddrW-1:0] raddr,
   output logic      [15:0]      rdata
);

   logic [15:0] mem [Depth];

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read port; the data register holds its value between reads.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule
`default_nettype wire

// ===== design/tcw_cursor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tcw_cursor
// Cursor column, row and linear offset, and the decode of one character.
// ============================================================================
module tcw_cursor
   import tcw_pkg::*;
#(
   parameter int Columns = 80,
   parameter int Rows    = 25,
   parameter int AddrW   = 11
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             take,
   input  wire logic [7:0]       char_code,
   output tcw_cursor_type        dec,
   output logic      [AddrW-1:0] wr_addr,
   output logic      [7:0]       wr_char,
   output logic      [AddrW-1:0] pos
);

   localparam int ColW = $clog2(Columns);
   localparam int RowW = $clog2(Rows);
   localparam logic [ColW-1:0]  LastCol = ColW'(Columns - 1);
   localparam logic [RowW-1:0]  LastRow = RowW'(Rows - 1);
   localparam logic [AddrW-1:0] ColsA   = AddrW'(Columns);

   logic [ColW-1:0]  col_ff, col_in;
   logic [RowW-1:0]  row_ff, row_in;
   logic [AddrW-1:0] pos_ff, pos_in;
   logic [AddrW-1:0] line_start;
   logic             is_print;

   assign pos        = pos_ff;
   assign line_start = pos_ff - AddrW'(col_ff);
   // Printable codes are 0x20 through 0x7F.
   assign is_print   = !char_code[7] && (char_code[6:5] != 2'b00);

   // Decode the character and work out the next cursor position.
   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      pos_in     = pos_ff;
      dec.store  = 1'b0;
      dec.scroll = 1'b0;
      wr_addr    = pos_ff;
      wr_char    = char_code;
      if (char_code == CODE_CR) begin
         col_in = '0;
         pos_in = line_start;
      end else if (char_code == CODE_LF || is_print) begin
         dec.store = is_print;
         if (is_print && col_ff != LastCol) begin
            col_in = col_ff + 1'b1;
            pos_in = pos_ff + 1'b1;
         end else begin
            // New line; at the bottom row the screen scrolls instead.
            col_in = '0;
            if (row_ff == LastRow) begin
               dec.scroll = 1'b1;
               pos_in     = line_start;
            end else begin
               row_in = row_ff + 1'b1;
               pos_in = line_start + ColsA;
            end
         end
      end else if (char_code == CODE_BACKSPACE) begin
         dec.store = 1'b1;
         wr_char   = BLANK_CHAR;
         if (pos_ff != '0) begin
            wr_addr = pos_ff - 1'b1;
            pos_in  = pos_ff - 1'b1;
            if (col_ff != '0) begin
               col_in = col_ff - 1'b1;
            end else begin
               row_in = row_ff - 1'b1;
               col_in = LastCol;
            end
         end else begin
            wr_addr = '0;
         end
      end
   end

   // Cursor registers move only when a write beat is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         pos_ff <= '0;
      end else if (take) begin
         col_ff <= col_in;
         row_ff <= row_in;
         pos_ff <= pos_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/tcw_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tcw_sequencer
// Control sequencer: clearing pass, request handling, scroll sweep and
// response strobe, with one address counter shared by all sweeps.
// ============================================================================
module tcw_sequencer
   import tcw_pkg::*;
#(
   parameter int Columns = 80,
   parameter int Rows    = 25,
   parameter int AddrW   = 11
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic             req_kind,
   input  wire logic [10:0]      req_cell_index,
   input  wire tcw_cursor_type   dec,
   input  wire logic [AddrW-1:0] cur_waddr,
   input  wire logic [7:0]       cur_char,
   input  wire logic [7:0]       attr,
   output logic                  take_write,
   output logic                  ram_we,
   output logic      [AddrW-1:0] ram_waddr,
   output logic      [15:0]      ram_wdata,
   output logic                  ram_re,
   output logic      [AddrW-1:0] ram_raddr,
   input  wire logic [15:0]      ram_rdata,
   output logic                  rsp_valid,
   output logic      [15:0]      rsp_cell_data,
   output logic                  rsp_scrolled
);

   localparam int Cells = Columns * Rows;
   localparam logic [AddrW-1:0] LastCell = AddrW'(Cells - 1);
   localparam logic [AddrW-1:0] LastCopy = AddrW'(Cells - Columns - 1);
   localparam logic [AddrW-1:0] ColsA    = AddrW'(Columns);

   tcw_state_type    state_ff, state_in;
   logic [AddrW-1:0] cnt_ff, cnt_in;
   logic             read_ff, read_in;
   logic             oob_ff, oob_in;
   logic             scroll_ff, scroll_in;

   // Write stage: a sweep beat writes the memory in the cycle after it is issued.
   logic             stage_vld_ff, stage_vld_in;
   logic             stage_copy_ff, stage_copy_in;
   logic [AddrW-1:0] stage_addr_ff, stage_addr_in;
   logic [15:0]      stage_fill_ff, stage_fill_in;

   logic             accept;
   logic [31:0]      idx32;
   logic             idx_oob;

   assign busy       = (state_ff != ST_IDLE) || stage_vld_ff;
   assign accept     = start && !busy;
   assign take_write = accept && (req_kind == KIND_WRITE);
   assign idx32      = 32'(req_cell_index);
   assign idx_oob    = idx32 >= 32'(Cells);

   // Response ports come straight from the response state.
   assign rsp_valid     = (state_ff == ST_RESP);
   assign rsp_cell_data = (read_ff && !oob_ff) ? ram_rdata : 16'h0000;
   assign rsp_scrolled  = scroll_ff;

   // Memory write port: sweep beats first, else the character write.
   always_comb begin
      if (stage_vld_ff) begin
         ram_we    = 1'b1;
         ram_waddr = stage_addr_ff;
         ram_wdata = stage_copy_ff ? ram_rdata : stage_fill_ff;
      end else begin
         ram_we    = take_write && dec.store;
         ram_waddr = cur_waddr;
         ram_wdata = {attr, cur_char};
      end
   end

   // Next state, counter and sweep beats.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      read_in       = read_ff;
      oob_in        = oob_ff;
      scroll_in     = scroll_ff;
      stage_vld_in  = 1'b0;
      stage_copy_in = 1'b0;
      stage_addr_in = cnt_ff;
      stage_fill_in = {attr, BLANK_CHAR};
      ram_re        = 1'b0;
      ram_raddr     = idx_oob ? '0 : idx32[AddrW-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            stage_vld_in  = 1'b1;
            stage_fill_in = RESET_CELL;
            if (cnt_ff == LastCell) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_READ) begin
                  ram_re    = 1'b1;
                  read_in   = 1'b1;
                  oob_in    = idx_oob;
                  scroll_in = 1'b0;
                  state_in  = ST_RESP;
               end else begin
                  read_in   = 1'b0;
                  oob_in    = 1'b0;
                  scroll_in = dec.scroll;
                  cnt_in    = '0;
                  state_in  = dec.scroll ? ST_COPY : ST_RESP;
               end
            end
         end
         ST_COPY: begin
            // Read the cell one line below and write it here in the next cycle.
            ram_re        = 1'b1;
            ram_raddr     = cnt_ff + ColsA;
            stage_vld_in  = 1'b1;
            stage_copy_in = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == LastCopy) begin
               state_in = ST_BLANK;
            end
         end
         ST_BLANK: begin
            stage_vld_in = 1'b1;
            if (cnt_ff == LastCell) begin
               cnt_in   = '0;
               state_in = ST_RESP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         read_ff      <= 1'b0;
         oob_ff       <= 1'b0;
         scroll_ff    <= 1'b0;
         stage_vld_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         read_ff      <= read_in;
         oob_ff       <= oob_in;
         scroll_ff    <= scroll_in;
         stage_vld_ff <= stage_vld_in;
      end
   end

   // Write stage payload.
   always_ff @(posedge clock) begin
      stage_copy_ff <= stage_copy_in;
      stage_addr_ff <= stage_addr_in;
      stage_fill_ff <= stage_fill_in;
   end

   // A taken beat always leads to a busy cycle before the next one.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted beat not followed by busy");

   // A pending sweep write never meets a character write.
   a_stage_blocks: assert property (@(posedge clock) disable iff (reset)
      stage_vld_ff |-> !accept)
      else $error("sweep write collides with a request");

   // The copy phase only ends in the blanking phase.
   a_copy_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY) |=> (state_ff == ST_COPY || state_ff == ST_BLANK))
      else $error("copy phase left out of order");

   // A scrolled response never carries read data.
   a_scroll_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scrolled) |-> !read_ff)
      else $error("scroll flagged on a read response");

endmodule
`default_nettype wire

// ===== design/text_console_char_writer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// text_console_char_writer
// Text-mode teletype: a COLUMNS x ROWS screen of 16-bit cells with a cursor.
// ============================================================================
// After reset the block is busy while it fills the screen with white-on-black
// blanks, one cell a cycle. For a read or an ordinary write, the beat is taken
// when start is high and busy is low, and the result strobes on rsp_valid in
// the next cycle. A write that scrolls stays busy while the single memory
// port pair moves one cell a cycle and then blanks the bottom line. The result
// beat is shown for exactly one cycle and cannot be held off by the receiver.
// The attribute register may be written at any time the block is idle.
// ============================================================================
module text_console_char_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_char_code,
   input  wire logic [10:0] req_cell_index,
   output logic             rsp_valid,
   output logic      [15:0] rsp_cell_data,
   output logic      [10:0] rsp_cursor_offset,
   output logic             rsp_scrolled,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data
);

   localparam int Cells = COLUMNS * ROWS;
   localparam int AddrW = $clog2(Cells);

   logic [7:0]       attr_ff;
   tcw_cursor_type   dec;
   logic [AddrW-1:0] cur_waddr;
   logic [7:0]       cur_char;
   logic [AddrW-1:0] pos;
   logic [31:0]      pos32;
   logic             take_write;
   logic             ram_we;
   logic [AddrW-1:0] ram_waddr;
   logic [15:0]      ram_wdata;
   logic             ram_re;
   logic [AddrW-1:0] ram_raddr;
   logic [15:0]      ram_rdata;

   // Attribute register; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= RESET_ATTRIBUTE;
      end else if (csr_valid && csr_ready) begin
         attr_ff <= csr_data;
      end
   end

   // Cursor offset reported on every result.
   assign pos32             = 32'(pos);
   assign rsp_cursor_offset = pos32[10:0];

   tcw_cursor #(
      .Columns (COLUMNS),
      .Rows    (ROWS),
      .AddrW   (AddrW)
   ) u_cursor (
      .clock     (clock),
      .reset     (reset),
      .take      (take_write),
      .char_code (req_char_code),
      .dec       (dec),
      .wr_addr   (cur_waddr),
      .wr_char   (cur_char),
      .pos       (pos)
   );

   tcw_sequencer #(
      .Columns (COLUMNS),
      .Rows    (ROWS),
      .AddrW   (AddrW)
   ) u_sequencer (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_cell_index (req_cell_index),
      .dec            (dec),
      .cur_waddr      (cur_waddr),
      .cur_char       (cur_char),
      .attr           (attr_ff),
      .take_write     (take_write),
      .ram_we         (ram_we),
      .ram_waddr      (ram_waddr),
      .ram_wdata      (ram_wdata),
      .ram_re         (ram_re),
      .ram_raddr      (ram_raddr),
      .ram_rdata      (ram_rdata),
      .rsp_valid      (rsp_valid),
      .rsp_cell_data  (rsp_cell_data),
      .rsp_scrolled   (rsp_scrolled)
   );

   tcw_screen_ram #(
      .Depth (Cells),
      .AddrW (AddrW)
   ) u_screen_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule
`default_nettype wire

// ===== tb/tcw_console_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tcw_console_checker
// Watches the ports of the text console character writer and checks every
// result beat against its own model of the screen and cursor.
// ============================================================================
// The model keeps a copy of the screen, the cursor and the attribute. Each
// command beat that the block takes is played into the model, and the result
// it should give is queued. Each result beat is compared field by field with
// the oldest queued result. Attribute writes update the model's attribute.
// ============================================================================
module tcw_console_checker
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_char_code,
   input  wire logic [10:0] req_cell_index,
   input  wire logic        rsp_valid,
   input  wire logic [15:0] rsp_cell_data,
   input  wire logic [10:0] rsp_cursor_offset,
   input  wire logic        rsp_scrolled,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [7:0]  csr_data,
   output int               error_count,
   output int               replies_open,
   output int               replies_seen,
   output int               scroll_count
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam logic [7:0] FIRST_HIGH_BYTE = 8'h80;

   // What one result beat should carry.
   typedef struct packed {
      logic [15:0] cell_data;
      logic [10:0] cursor_offset;
      logic        scrolled;
   } console_reply_type;

   logic [15:0]       screen_image [0:CELLS-1];
   int unsigned       col_now;
   int unsigned       row_now;
   logic [7:0]        attr_now;
   console_reply_type reply_q [$];
   console_reply_type next_reply;
   int                errors;
   int                seen;
   int                scrolls;

   // One line per mismatch, and each one is counted.
   task automatic flag_error(input string msg);
      $display("%0t checker: %s", $time, msg);
      errors++;
   endtask

   function automatic logic [15:0] blank_cell();
      return {attr_now, BLANK_CHAR};
   endfunction

   // Screen state right after reset.
   task automatic clear_console();
      for (int i = 0; i < CELLS; i++)
         screen_image[i] = RESET_CELL;
      col_now  = 0;
      row_now  = 0;
      attr_now = RESET_ATTRIBUTE;
      reply_q.delete();
   endtask

   // Plays one command into the screen model and works out its result.
   task automatic emulate_teletype(input logic kind, input logic [7:0] code,
                                   input logic [10:0] index,
                                   output console_reply_type reply);
      int unsigned pos;
      reply = '0;
      if (kind == KIND_READ) begin
         if (index < CELLS)
            reply.cell_data = screen_image[index];
      end else begin
         pos = row_now * COLUMNS + col_now;
         if (code == CODE_CR) begin
            col_now = 0;
         end else if (code == CODE_LF) begin
            col_now = 0;
            row_now++;
         end else if (code == CODE_BACKSPACE) begin
            // The blank lands one cell back, or on cell 0 when at home.
            if (pos > 0)
               pos--;
            if (col_now > 0) begin
               col_now--;
            end else if (row_now > 0) begin
               row_now--;
               col_now = COLUMNS - 1;
            end
            screen_image[pos] = blank_cell();
         end else if (code >= BLANK_CHAR && code < FIRST_HIGH_BYTE) begin
            screen_image[pos] = {attr_now, code};
            col_now++;
            if (col_now >= COLUMNS) begin
               col_now = 0;
               row_now++;
            end
         end
         // Leaving the bottom row moves every line up and blanks the last one.
         if (row_now >= ROWS) begin
            for (int i = 0; i < CELLS; i++)
               screen_image[i] = (i < CELLS - COLUMNS) ? screen_image[i + COLUMNS]
                                                       : blank_cell();
            row_now = ROWS - 1;
            reply.scrolled = 1'b1;
            scrolls++;
         end
      end
      reply.cursor_offset = 11'(row_now * COLUMNS + col_now);
   endtask

   // Compares a result beat with the oldest outstanding result.
   task automatic check_reply();
      console_reply_type want;
      seen++;
      if (reply_q.size() == 0) begin
         flag_error($sformatf("result beat with no command outstanding (data %h offset %0d)",
                              rsp_cell_data, rsp_cursor_offset));
      end else begin
         want = reply_q.pop_front();
         if (rsp_cell_data !== want.cell_data)
            flag_error($sformatf("cell_data %h, expected %h", rsp_cell_data, want.cell_data));
         if (rsp_cursor_offset !== want.cursor_offset)
            flag_error($sformatf("cursor_offset %0d, expected %0d",
                                 rsp_cursor_offset, want.cursor_offset));
         if (rsp_scrolled !== want.scrolled)
            flag_error($sformatf("scrolled %b, expected %b", rsp_scrolled, want.scrolled));
      end
   endtask

   // Everything is sampled at the rising edge; results go out by nonblocking
   // assignment so the stimulus side always sees a settled value.
   always @(posedge clock) begin
      if (reset) begin
         clear_console();
      end else begin
         if (start && !busy) begin
            emulate_teletype(req_kind, req_char_code, req_cell_index, next_reply);
            reply_q.push_back(next_reply);
         end
         if (rsp_valid)
            check_reply();
         if (csr_valid && csr_ready)
            attr_now = csr_data;
      end
      error_count  <= errors;
      replies_open <= reply_q.size();
      replies_seen <= seen;
      scroll_count <= scrolls;
   end

endmodule

// ===== tb/tb_text_console_char_writer.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_text_console_char_writer
// Self-checking testbench for the text console character writer.
// ============================================================================
// A short directed sequence covers reads at and past the screen edge,
// backspace at home and across a line start, control and high bytes, and the
// line wrap. Random traffic follows in several phases, each under a different
// attribute: lines of printable text ended by CR and LF, read bursts, runs of
// backspaces and noise bytes; most phases put random idle gaps between beats.
// A checker beside the block predicts and compares every result beat.
// ============================================================================
module tb_text_console_char_writer;
   import tcw_pkg::*;

   localparam int COLUMNS      = 80;
   localparam int ROWS         = 25;
   localparam int CELLS        = COLUMNS * ROWS;
   localparam int PHASES       = 5;
   localparam int PHASE_ITEMS  = 166;
   localparam int SETTLE_TICKS = 8;
   localparam longint TIMEOUT_NS = 64'd100_000_000;
   localparam logic [7:0] FIRST_HIGH_BYTE = 8'h80;
   localparam logic [7:0] LAST_PRINTABLE  = 8'h7F;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_kind;
   logic [7:0]  req_char_code;
   logic [10:0] req_cell_index;
   logic        rsp_valid;
   logic [15:0] rsp_cell_data;
   logic [10:0] rsp_cursor_offset;
   logic        rsp_scrolled;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_data;

   int error_count;
   int replies_open;
   int replies_seen;
   int scroll_count;
   int n_reads;
   int n_writes;
   int n_attr_writes;
   bit idle_on;

   text_console_char_writer #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_char_code    (req_char_code),
      .req_cell_index   (req_cell_index),
      .rsp_valid        (rsp_valid),
      .rsp_cell_data    (rsp_cell_data),
      .rsp_cursor_offset(rsp_cursor_offset),
      .rsp_scrolled     (rsp_scrolled),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   tcw_console_checker #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) i_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_char_code    (req_char_code),
      .req_cell_index   (req_cell_index),
      .rsp_valid        (rsp_valid),
      .rsp_cell_data    (rsp_cell_data),
      .rsp_cursor_offset(rsp_cursor_offset),
      .rsp_scrolled     (rsp_scrolled),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .error_count      (error_count),
      .replies_open     (replies_open),
      .replies_seen     (replies_seen),
      .scroll_count     (scroll_count)
   );

   // Clock.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Hard stop in case the block hangs.
   initial begin
      #(TIMEOUT_NS);
      $display("tb_text_console_char_writer: FAIL");
      $finish;
   end

   // Idle cycles before a beat: mostly none or a few, now and then a long one.
   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (!idle_on || pick < 50)
         return 0;
      else if (pick < 85)
         return $urandom_range(1, 3);
      else if (pick < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Drives one command beat and holds it until the block takes it.
   task automatic send_cmd(input logic kind, input logic [7:0] code,
                           input logic [10:0] index);
      int gap;
      gap = idle_gap();
      @(negedge clock);
      if (gap > 0) begin
         start          = 1'b0;
         req_kind       = 1'($urandom_range(0, 1));
         req_char_code  = 8'($urandom_range(0, 255));
         req_cell_index = 11'($urandom_range(0, 2047));
         repeat (gap) @(negedge clock);
      end
      start          = 1'b1;
      req_kind       = kind;
      req_char_code  = code;
      req_cell_index = index;
      do @(posedge clock); while (busy !== 1'b0);
      if (kind == KIND_READ)
         n_reads++;
      else
         n_writes++;
   endtask

   task automatic put_char(input logic [7:0] code);
      send_cmd(KIND_WRITE, code, 11'($urandom_range(0, 2047)));
   endtask

   task automatic read_cell(input int index);
      send_cmd(KIND_READ, 8'($urandom_range(0, 255)), 11'(index));
   endtask

   // A read mostly on the screen, sometimes past its end.
   task automatic read_any_cell();
      if ($urandom_range(0, 99) < 85)
         read_cell($urandom_range(0, CELLS - 1));
      else
         read_cell($urandom_range(CELLS, 2047));
   endtask

   // Stops issuing, waits for every result, then lets the block settle.
   task automatic drain_results();
      @(negedge clock);
      start = 1'b0;
      do @(posedge clock); while (replies_open != 0);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // One beat on the attribute register channel.
   task automatic write_attribute(input logic [7:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid = 1'b0;
      csr_data  = 8'($urandom_range(0, 255));
      n_attr_writes++;
   endtask

   // Random traffic, mostly text lines, until the beat count is reached.
   task automatic run_traffic(input int beats);
      int target;
      int pick;
      int len;
      int mix;
      target = n_reads + n_writes + beats;
      while (n_reads + n_writes < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            // A line of text, long enough to wrap now and then.
            len = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 12)
                                               : $urandom_range(60, 100);
            for (int i = 0; i < len; i++) begin
               mix = $urandom_range(0, 99);
               if (mix < 85)
                  put_char(8'($urandom_range(BLANK_CHAR, LAST_PRINTABLE)));
               else if (mix < 91)
                  put_char(CODE_BACKSPACE);
               else if (mix < 95)
                  read_any_cell();
               else if (mix < 97)
                  put_char(8'($urandom_range(0, BLANK_CHAR - 1)));
               else
                  put_char(8'($urandom_range(FIRST_HIGH_BYTE, 255)));
            end
            mix = $urandom_range(0, 99);
            if (mix < 80 && mix >= 60)
               put_char(CODE_CR);
            if (mix < 80)
               put_char(CODE_LF);
            else if (mix < 90)
               put_char(CODE_CR);
         end else if (pick < 80) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
               read_any_cell();
         end else if (pick < 92) begin
            // Any byte at all.
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++)
               put_char(8'($urandom_range(0, 255)));
         end else begin
            // A run of backspaces, often back across line starts.
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++)
               put_char(CODE_BACKSPACE);
         end
      end
   endtask

   // Stimulus and verdict.
   initial begin
      logic [7:0] phase_attr;
      reset          = 1'b1;
      start          = 1'b0;
      req_kind       = KIND_WRITE;
      req_char_code  = 8'h00;
      req_cell_index = 11'd0;
      csr_valid      = 1'b0;
      csr_data       = 8'h00;
      n_reads        = 0;
      n_writes       = 0;
      n_attr_writes  = 0;
      idle_on        = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset contents, reads at and past the end of the screen.
      read_cell(0);
      read_cell(CELLS - 1);
      read_cell(CELLS);
      read_cell(2047);
      // Backspace at home blanks cell 0 and leaves the cursor there.
      put_char(CODE_BACKSPACE);
      put_char(8'h41);
      put_char(LAST_PRINTABLE);
      put_char(BLANK_CHAR);
      // Control and high bytes change nothing.
      put_char(8'h00);
      put_char(8'(BLANK_CHAR - 1));
      put_char(FIRST_HIGH_BYTE);
      put_char(8'hFF);
      put_char(CODE_CR);
      put_char(CODE_LF);
      // Backspace from a line start goes to the last column above, and the
      // next character there wraps the line.
      put_char(CODE_BACKSPACE);
      put_char(8'h7E);
      read_cell(0);
      read_cell(1);
      read_cell(COLUMNS - 1);
      read_cell(COLUMNS);
      drain_results();

      // Random phases, each under its own attribute; some without idling.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       phase_attr = 8'hFF;
            1:       phase_attr = 8'h00;
            PHASES - 1: phase_attr = RESET_ATTRIBUTE;
            default: phase_attr = 8'($urandom_range(0, 255));
         endcase
         write_attribute(phase_attr);
         idle_on = (p % 3) != 0;
         run_traffic(PHASE_ITEMS);
         drain_results();
      end

      $display("Run covered %0d commands (%0d writes, %0d reads) under %0d attribute settings,",
               n_reads + n_writes, n_writes, n_reads, n_attr_writes);
      $display("with %0d results checked and %0d screen scrolls.", replies_seen, scroll_count);
      if (error_count == 0 && replies_open == 0)
         $display("tb_text_console_char_writer: PASS");
      else
         $display("tb_text_console_char_writer: FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/tcw_pkg.sv
design/tcw_screen_ram.sv
design/tcw_cursor.sv
design/tcw_sequencer.sv
design/text_console_char_writer.sv
tb/tcw_console_checker.sv
tb/tb_text_console_char_writer.sv
